>>> rtl/core/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and constants for the directional intra predictor: request
// and register codes, the front-to-back queue entry and queue status.
// ----------------------------------------------------------------------------
package dip_pkg;

    localparam int SAMPLE_W  = 12;   // stored and predicted sample width
    localparam int EIDX_W    = 9;    // signed edge index on the input port
    localparam int IDX_W     = 13;   // signed edge index inside the datapath
    localparam int EDGE_BIAS = 16;   // store entry 0 holds edge index -16
    localparam int WGT_W     = 5;
    localparam int PROD_W    = 17;   // (6-bit + 1) * 10-bit step
    localparam int POS_W     = 19;   // signed 1/64 position

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // request types
    localparam logic [1:0] REQ_WR_ABOVE = 2'd0;
    localparam logic [1:0] REQ_WR_LEFT  = 2'd1;
    localparam logic [1:0] REQ_PREDICT  = 2'd2;

    // angle zones (zone 0 behaves as zone 1)
    localparam logic [1:0] ZONE_MIXED = 2'd2;
    localparam logic [1:0] ZONE_LEFT  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPS_ABOVE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UPS_LEFT     = 3'd6;

    typedef enum logic [1:0] {
        OP_WR_ABOVE,
        OP_WR_LEFT,
        OP_PREDICT
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic                        sel_left;  // predict reads the left store
        logic signed [IDX_W-1:0]     idx;       // write index or first tap
        logic [WGT_W-1:0]            weight;    // weight of the second tap
        logic [SAMPLE_W-1:0]         value;     // write data
    } qentry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } qstat_t;

endpackage

>>> rtl/core/dip_front.sv
// ----------------------------------------------------------------------------
// dip_front
// Holds the configuration registers, accepts requests, and turns each one
// into a queue entry: store writes pass through, predictions get their
// edge store, first tap index and blend weight.
// ----------------------------------------------------------------------------
module dip_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic signed [dip_pkg::EIDX_W-1:0]   edge_index,
    input  logic [dip_pkg::SAMPLE_W-1:0]        edge_value,
    input  logic [5:0]                          pixel_row,
    input  logic [5:0]                          pixel_col,
    input  logic                                cfg_write,
    input  logic [dip_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dip_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  dip_pkg::qstat_t                     q_stat,
    output logic                                push,
    output dip_pkg::qentry_t                    push_entry
);

    localparam int IW = dip_pkg::IDX_W;
    localparam int PW = dip_pkg::POS_W;
    localparam int CW = dip_pkg::QCNT_W + 1;

    // configuration
    logic [1:0] zone_reg;
    logic [6:0] block_width_reg;
    logic [6:0] block_height_reg;
    logic [9:0] step_x_reg;
    logic [9:0] step_y_reg;
    logic       ups_above_reg;
    logic       ups_left_reg;

    // stage A
    logic                               a_valid_reg;
    logic [1:0]                         a_req_reg;
    logic signed [dip_pkg::EIDX_W-1:0]  a_eidx_reg;
    logic [dip_pkg::SAMPLE_W-1:0]       a_value_reg;
    logic [5:0]                         a_row_reg;
    logic [5:0]                         a_col_reg;
    logic [dip_pkg::PROD_W-1:0]         a_prodx_reg;
    logic [dip_pkg::PROD_W-1:0]         a_prody_reg;

    logic                               accept;
    logic [6:0]                         row_p1;
    logic [6:0]                         col_p1;
    logic [dip_pkg::PROD_W-1:0]         prodx_next;
    logic [dip_pkg::PROD_W-1:0]         prody_next;
    logic [CW-1:0]                      occupancy;

    assign occupancy = CW'(q_stat.count) + CW'(a_valid_reg);
    assign busy      = occupancy >= CW'(dip_pkg::QDEPTH);
    assign accept    = start && !busy;

    assign row_p1     = {1'b0, pixel_row} + 7'd1;
    assign col_p1     = {1'b0, pixel_col} + 7'd1;
    assign prodx_next = dip_pkg::PROD_W'(row_p1) * dip_pkg::PROD_W'(step_x_reg);
    assign prody_next = dip_pkg::PROD_W'(col_p1) * dip_pkg::PROD_W'(step_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg         <= 2'd1;
            block_width_reg  <= 7'd4;
            block_height_reg <= 7'd4;
            step_x_reg       <= 10'd64;
            step_y_reg       <= 10'd64;
            ups_above_reg    <= 1'b0;
            ups_left_reg     <= 1'b0;
            a_valid_reg      <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            if (cfg_write)
            begin
                case (cfg_index)
                    dip_pkg::CFG_ZONE:         zone_reg         <= cfg_data[1:0];
                    dip_pkg::CFG_BLOCK_WIDTH:  block_width_reg  <= cfg_data[6:0];
                    dip_pkg::CFG_BLOCK_HEIGHT: block_height_reg <= cfg_data[6:0];
                    dip_pkg::CFG_STEP_X:       step_x_reg       <= cfg_data;
                    dip_pkg::CFG_STEP_Y:       step_y_reg       <= cfg_data;
                    dip_pkg::CFG_UPS_ABOVE:    ups_above_reg    <= cfg_data[0];
                    dip_pkg::CFG_UPS_LEFT:     ups_left_reg     <= cfg_data[0];
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_req_reg   <= req_type;
            a_eidx_reg  <= edge_index;
            a_value_reg <= edge_value;
            a_row_reg   <= pixel_row;
            a_col_reg   <= pixel_col;
            a_prodx_reg <= prodx_next;
            a_prody_reg <= prody_next;
        end
    end

    // floor(v / 64) or floor(v / 32) for an upsampled edge
    function automatic logic signed [IW-1:0] pos_base(logic signed [PW-1:0] v, logic ups);
        logic signed [PW-1:0] s;
        begin
            s = ups ? (v >>> 5) : (v >>> 6);
            return IW'(s);
        end
    endfunction

    function automatic logic [dip_pkg::WGT_W-1:0] pos_weight(logic signed [PW-1:0] v,
                                                             logic ups);
        return ups ? v[4:0] : v[5:1];
    endfunction

    // stage B: classify and address
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_a;
    logic signed [PW-1:0] pos_l;
    logic signed [IW-1:0] base_x;
    logic signed [IW-1:0] min_x;
    logic signed [IW-1:0] edge_last;
    logic signed [IW-1:0] clamp_idx;
    logic signed [IW-1:0] run_idx;
    logic signed [PW-1:0] pos_sel;
    logic                 ups_sel;
    logic [5:0]           inner;
    logic                 clamp_left;

    assign pos_x = $signed({1'b0, a_col_reg, 6'd0}) - $signed({2'b00, a_prodx_reg});
    assign pos_y = $signed({1'b0, a_row_reg, 6'd0}) - $signed({2'b00, a_prody_reg});
    assign pos_a = $signed({2'b00, a_prodx_reg});
    assign pos_l = $signed({2'b00, a_prody_reg});
    assign base_x = pos_base(pos_x, ups_above_reg);
    assign min_x  = ups_above_reg ? -IW'(2) : -IW'(1);

    // zones 1 and 3 differ only in the edge they walk along
    assign clamp_left = (zone_reg == dip_pkg::ZONE_LEFT);
    assign pos_sel    = clamp_left ? pos_l : pos_a;
    assign ups_sel    = clamp_left ? ups_left_reg : ups_above_reg;
    assign inner      = clamp_left ? a_row_reg : a_col_reg;
    assign edge_last  = (IW'(block_width_reg) + IW'(block_height_reg) - IW'(1))
                        <<< ups_sel;
    assign run_idx    = pos_base(pos_sel, ups_sel)
                        + (ups_sel ? IW'({inner, 1'b0}) : IW'(inner));
    assign clamp_idx  = (run_idx >= edge_last) ? edge_last : run_idx;

    always_comb
    begin
        push_entry          = '0;
        push_entry.value    = a_value_reg;
        push_entry.idx      = IW'(a_eidx_reg);
        push                = a_valid_reg;
        case (a_req_reg)
            dip_pkg::REQ_WR_ABOVE: push_entry.op = dip_pkg::OP_WR_ABOVE;
            dip_pkg::REQ_WR_LEFT:  push_entry.op = dip_pkg::OP_WR_LEFT;
            dip_pkg::REQ_PREDICT:
            begin
                push_entry.op = dip_pkg::OP_PREDICT;
                if (zone_reg == dip_pkg::ZONE_MIXED)
                begin
                    if (base_x >= min_x)
                    begin
                        push_entry.sel_left = 1'b0;
                        push_entry.idx      = base_x;
                        push_entry.weight   = pos_weight(pos_x, ups_above_reg);
                    end
                    else
                    begin
                        push_entry.sel_left = 1'b1;
                        push_entry.idx      = pos_base(pos_y, ups_left_reg);
                        push_entry.weight   = pos_weight(pos_y, ups_left_reg);
                    end
                end
                else
                begin
                    // past the last edge sample: weight 0 returns that sample
                    push_entry.sel_left = clamp_left;
                    push_entry.idx      = clamp_idx;
                    push_entry.weight   = (run_idx >= edge_last) ? '0
                                          : pos_weight(pos_sel, ups_sel);
                end
            end
            default: push = 1'b0;
        endcase
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CW'(dip_pkg::QDEPTH))
        else $error("front: queue plus stage A exceed queue depth");

    a_push_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(accept))
        else $error("front: push without an accepted request");

endmodule

>>> rtl/core/dip_queue.sv
// ----------------------------------------------------------------------------
// dip_queue
// Short FIFO of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module dip_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dip_pkg::qentry_t push_entry,
    input  logic             pop,
    output dip_pkg::qentry_t head,
    output dip_pkg::qstat_t  stat
);

    dip_pkg::qentry_t                 slot_reg [dip_pkg::QDEPTH];
    logic [dip_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dip_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dip_pkg::QCNT_W-1:0]       count_reg;
    logic [dip_pkg::QCNT_W-1:0]       count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = count_reg == dip_pkg::QCNT_W'(dip_pkg::QDEPTH);
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full || pop)
        else $error("queue: push while full");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue: pop while empty");

endmodule

>>> rtl/core/dip_back.sv
// ----------------------------------------------------------------------------
// dip_back
// Edge stores and interpolation: applies store writes, reads two adjacent
// edge samples for a prediction and blends them with a 5-bit weight.
// ----------------------------------------------------------------------------
module dip_back #(
    parameter int EDGE_DEPTH = 160
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dip_pkg::qentry_t               head,
    input  dip_pkg::qstat_t                q_stat,
    output logic                           pop,
    output logic                           done,
    output logic [dip_pkg::SAMPLE_W-1:0]   pred_pixel
);

    localparam int AW = $clog2(EDGE_DEPTH);
    localparam int KW = dip_pkg::IDX_W + 1;
    localparam int SW = dip_pkg::SAMPLE_W;

    logic [SW-1:0] above_mem [EDGE_DEPTH];
    logic [SW-1:0] left_mem  [EDGE_DEPTH];

    logic signed [KW-1:0] k0;
    logic signed [KW-1:0] k1;
    logic                 in0;
    logic                 in1;
    logic [AW-1:0]        addr0;
    logic [AW-1:0]        addr1;

    // read stage
    logic                      r_pred_reg;
    logic                      r_sel_left_reg;
    logic                      r_in0_reg;
    logic                      r_in1_reg;
    logic [dip_pkg::WGT_W-1:0] r_weight_reg;
    logic [SW-1:0]             r_a0_reg;
    logic [SW-1:0]             r_a1_reg;
    logic [SW-1:0]             r_l0_reg;
    logic [SW-1:0]             r_l1_reg;

    logic                      done_reg;
    logic [SW-1:0]             pred_pixel_reg;

    assign pop   = !q_stat.empty;
    assign k0    = KW'(head.idx) + KW'(dip_pkg::EDGE_BIAS);
    assign k1    = k0 + KW'(1);
    assign in0   = (k0 >= 0) && (k0 < $signed(KW'(EDGE_DEPTH)));
    assign in1   = (k1 >= 0) && (k1 < $signed(KW'(EDGE_DEPTH)));
    assign addr0 = k0[AW-1:0];
    assign addr1 = k1[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (pop && in0 && head.op == dip_pkg::OP_WR_ABOVE)
            above_mem[addr0] <= head.value;
        if (pop && in0 && head.op == dip_pkg::OP_WR_LEFT)
            left_mem[addr0] <= head.value;
        r_a0_reg <= above_mem[addr0];
        r_a1_reg <= above_mem[addr1];
        r_l0_reg <= left_mem[addr0];
        r_l1_reg <= left_mem[addr1];
        r_sel_left_reg <= head.sel_left;
        r_in0_reg      <= in0;
        r_in1_reg      <= in1;
        r_weight_reg   <= head.weight;
    end

    // taps outside the store read as zero
    logic [SW-1:0]         tap0;
    logic [SW-1:0]         tap1;
    logic [5:0]            w1;
    logic [5:0]            w0;
    logic [SW+6:0]         blend_sum;
    logic [SW-1:0]         pred_pixel_next;

    assign tap0 = !r_in0_reg ? '0 : (r_sel_left_reg ? r_l0_reg : r_a0_reg);
    assign tap1 = !r_in1_reg ? '0 : (r_sel_left_reg ? r_l1_reg : r_a1_reg);
    assign w1   = {1'b0, r_weight_reg};
    assign w0   = 6'd32 - w1;
    assign blend_sum = (SW+7)'(tap0) * (SW+7)'(w0) + (SW+7)'(tap1) * (SW+7)'(w1)
                       + (SW+7)'(16);
    assign pred_pixel_next = blend_sum[SW+4:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_pred_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            r_pred_reg <= pop && head.op == dip_pkg::OP_PREDICT;
            done_reg   <= r_pred_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_pred_reg)
            pred_pixel_reg <= pred_pixel_next;
    end

    assign done       = done_reg;
    assign pred_pixel = pred_pixel_reg;

    a_done_from_predict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pop, 2) && $past(head.op, 2) == dip_pkg::OP_PREDICT)
        else $error("back: result without a popped predict request");

endmodule

>>> rtl/core/directional_intra_predictor.sv
// ----------------------------------------------------------------------------
// directional_intra_predictor
// Results: an accepted request passes stage A, the queue and the back-end read
// stage before done rises (done high for one cycle, pred_pixel valid with it).
// Throughput: one request per clock while busy is low; the back end drains
// the queue every cycle, so busy rises only if queue and stage A hold 4.
// Reset: configuration to zone 1, 4x4 block, steps 64, no upsampling; the
// queue and pipelines empty; edge stores are not cleared.
// ----------------------------------------------------------------------------
module directional_intra_predictor #(
    parameter int EDGE_DEPTH = 160
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic signed [dip_pkg::EIDX_W-1:0]   edge_index,
    input  logic [dip_pkg::SAMPLE_W-1:0]        edge_value,
    input  logic [5:0]                          pixel_row,
    input  logic [5:0]                          pixel_col,
    input  logic                                cfg_write,
    input  logic [dip_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dip_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                done,
    output logic [dip_pkg::SAMPLE_W-1:0]        pred_pixel
);

    dip_pkg::qstat_t  q_stat;
    dip_pkg::qentry_t push_entry;
    dip_pkg::qentry_t head;
    logic             push;
    logic             pop;

    dip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .edge_index (edge_index),
        .edge_value (edge_value),
        .pixel_row  (pixel_row),
        .pixel_col  (pixel_col),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    dip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    dip_back #(
        .EDGE_DEPTH (EDGE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .done       (done),
        .pred_pixel (pred_pixel)
    );

endmodule
